@@ rtl/ofsq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ofsq_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_FLOW_DISABLED = 3'd0,
      CSR_ADAPTIVE_STD  = 3'd1,
      CSR_FIXED_STD     = 3'd2,
      CSR_MAX_CONSEC    = 3'd3,
      CSR_VALID_THRESH  = 3'd4,
      CSR_DT_MAX_US     = 3'd5,
      CSR_MIN_QUALITY   = 3'd6
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 32;

   // Register reset values
   localparam logic        RST_FLOW_DISABLED = 1'b0;
   localparam logic        RST_ADAPTIVE_STD  = 1'b0;
   localparam logic [15:0] RST_FIXED_STD     = 16'd2048;
   localparam logic [15:0] RST_MAX_CONSEC    = 16'd50;
   localparam logic [4:0]  RST_VALID_THRESH  = 5'd4;
   localparam logic [31:0] RST_DT_MAX_US     = 32'd35000;
   localparam logic [7:0]  RST_MIN_QUALITY   = 8'd90;

   // Deltas at or beyond this magnitude are rejected
   localparam logic signed [15:0] MAG_LIMIT = 16'sd100;

   // Adaptive std: 0.0007984 * shutter + 0.4335 in Q.26, rounded to Q6.10.
   // The offset already carries the rounding half (2^15).
   localparam logic [15:0] STD_SLOPE      = 16'd53580;
   localparam logic [31:0] STD_OFFSET_RND = 32'd29124461;
   localparam logic [15:0] STD_MIN        = 16'd102;    // 0.1 in Q6.10

   localparam logic [15:0] RUN_MAX = 16'hFFFF;

   typedef struct packed {
      logic        flow_disabled;
      logic        adaptive_std;
      logic [15:0] fixed_std;
      logic [15:0] max_consec;
      logic [4:0]  valid_thresh;
      logic [31:0] dt_max_us;
      logic [7:0]  min_quality;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic [7:0]         surface_quality;
      logic [15:0]        shutter_time;
      logic [31:0]        timestamp_us;
   } frame_type;

   typedef struct packed {
      logic signed [15:0] flow_x;
      logic signed [15:0] flow_y;
      logic [15:0]        std_dev;
      logic [31:0]        elapsed_us;
      logic               pushed;
      logic               update;
      logic               max_reached;
      logic               flow_valid;
      logic [4:0]         inlier_count;
      logic [15:0]        consec_outliers;
      logic [7:0]         outlier_total;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/ofsq_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ofsq_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [2:0]                        csr_index,
   input  wire logic [ofsq_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output ofsq_pkg::cfg_type                      cfg
);
   import ofsq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FLOW_DISABLED: cfg_in.flow_disabled = csr_write_data[0];
            CSR_ADAPTIVE_STD:  cfg_in.adaptive_std  = csr_write_data[0];
            CSR_FIXED_STD:     cfg_in.fixed_std     = csr_write_data[15:0];
            CSR_MAX_CONSEC:    cfg_in.max_consec    = csr_write_data[15:0];
            CSR_VALID_THRESH:  cfg_in.valid_thresh  = csr_write_data[4:0];
            CSR_DT_MAX_US:     cfg_in.dt_max_us     = csr_write_data[31:0];
            CSR_MIN_QUALITY:   cfg_in.min_quality   = csr_write_data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flow_disabled <= RST_FLOW_DISABLED;
         cfg_ff.adaptive_std  <= RST_ADAPTIVE_STD;
         cfg_ff.fixed_std     <= RST_FIXED_STD;
         cfg_ff.max_consec    <= RST_MAX_CONSEC;
         cfg_ff.valid_thresh  <= RST_VALID_THRESH;
         cfg_ff.dt_max_us     <= RST_DT_MAX_US;
         cfg_ff.min_quality   <= RST_MIN_QUALITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/ofsq_qualifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ofsq_qualifier #(
   parameter int unsigned WINDOW_LENGTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ofsq_pkg::cfg_type   cfg,
   input  wire ofsq_pkg::frame_type frame,
   input  wire logic        advance,
   output ofsq_pkg::result_type result
);
   import ofsq_pkg::*;

   localparam int unsigned CNT_W = $clog2(WINDOW_LENGTH + 1);
   localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;

   logic [WINDOW_LENGTH-1:0] history_ff, history_in;
   logic [CNT_W-1:0]         tally_ff, tally_in;
   logic [15:0]              run_ff, run_in;
   logic [7:0]               rejected_ff, rejected_in;
   logic [31:0]              last_push_ff, last_push_in;

   logic        mag_ok;
   logic [31:0] std_acc;
   logic [15:0] std_adapt;
   logic [15:0] std_val;
   logic        pushed;
   logic [31:0] elapsed;
   logic        update;
   logic        oldest;
   logic [15:0] run_step;
   logic        max_reached;

   // Magnitude gate on the raw deltas
   assign mag_ok = (frame.delta_x > -MAG_LIMIT) && (frame.delta_x < MAG_LIMIT) &&
                   (frame.delta_y > -MAG_LIMIT) && (frame.delta_y < MAG_LIMIT);

   // Adaptive std from shutter time, clamped below at 0.1
   assign std_acc   = frame.shutter_time * STD_SLOPE + STD_OFFSET_RND;
   assign std_adapt = (std_acc[31:16] < STD_MIN) ? STD_MIN : std_acc[31:16];

   always_comb begin
      if (!mag_ok)
         std_val = '0;
      else if (cfg.adaptive_std)
         std_val = std_adapt;
      else
         std_val = cfg.fixed_std;
   end

   // Push decision and elapsed time since last push
   assign pushed  = mag_ok && !cfg.flow_disabled;
   assign elapsed = pushed ? (frame.timestamp_us - last_push_ff) : '0;
   assign update  = pushed && (elapsed < cfg.dt_max_us) &&
                    (frame.surface_quality >= cfg.min_quality);

   assign last_push_in = pushed ? frame.timestamp_us : last_push_ff;
   assign rejected_in  = mag_ok ? rejected_ff : rejected_ff + 8'd1;

   // Sliding window with running inlier count
   assign oldest     = history_ff[WINDOW_LENGTH-1];
   assign history_in = {history_ff[WINDOW_LENGTH-2:0], update};

   always_comb begin
      tally_in = tally_ff;
      if (update && !oldest)
         tally_in = tally_ff + CNT_W'(1);
      else if (!update && oldest)
         tally_in = tally_ff - CNT_W'(1);
   end

   // Consecutive outlier run, saturating at the configured limit
   always_comb begin
      if (update)
         run_step = '0;
      else if (run_ff < RUN_MAX)
         run_step = run_ff + 16'd1;
      else
         run_step = run_ff;
   end

   assign max_reached = (run_step >= cfg.max_consec);
   assign run_in      = max_reached ? cfg.max_consec : run_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff   <= '0;
         tally_ff     <= '0;
         run_ff       <= '0;
         rejected_ff  <= '0;
         last_push_ff <= '0;
      end else if (advance) begin
         history_ff   <= history_in;
         tally_ff     <= tally_in;
         run_ff       <= run_in;
         rejected_ff  <= rejected_in;
         last_push_ff <= last_push_in;
      end
   end

   // Result assembly
   always_comb begin
      result.flow_x          = -frame.delta_y;
      result.flow_y          = -frame.delta_x;
      result.std_dev         = std_val;
      result.elapsed_us      = elapsed;
      result.pushed          = pushed;
      result.update          = update;
      result.max_reached     = max_reached;
      result.flow_valid      = (CMP_W'(tally_in) >= CMP_W'(cfg.valid_thresh));
      result.inlier_count    = 5'(tally_in);
      result.consec_outliers = run_in;
      result.outlier_total   = rejected_in;
   end

endmodule

`default_nettype wire

@@ rtl/optical_flow_sample_qualifier_unit.sv @@
// Optical-flow sample qualifier. Takes one sensor frame per transaction on
// the req_ channel and returns one qualified measurement per frame on the
// rsp_ channel: swapped and negated flow, standard deviation (Q6.10),
// elapsed time since the last pushed frame, push/update flags, and the
// sliding-window validity and consecutive-outlier status. Throughput is one
// frame per cycle while the rsp_ channel is not stalled; an accepted frame
// sits in the input register and moves into the result register once that
// register is free or drains, and rsp_valid rises as it moves. The window,
// counters and last push time are updated in the same cycle the frame moves
// into the result register, so back-to-back frames see each other's effect.
// Configuration registers are written through csr_ with no wait and should
// change only while no frame is in flight.
`timescale 1ns / 1ps
`default_nettype none

module optical_flow_sample_qualifier_unit #(
   parameter int unsigned WINDOW_LENGTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            csr_write_enable,
   input  wire logic [2:0]                      csr_index,
   input  wire logic [ofsq_pkg::CSR_DATA_W-1:0] csr_write_data,

   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic signed [15:0]              req_delta_x,
   input  wire logic signed [15:0]              req_delta_y,
   input  wire logic [7:0]                      req_surface_quality,
   input  wire logic [15:0]                     req_shutter_time,
   input  wire logic [31:0]                     req_timestamp_us,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [15:0]                   rsp_flow_x,
   output logic signed [15:0]                   rsp_flow_y,
   output logic [15:0]                          rsp_std_dev,
   output logic [31:0]                          rsp_elapsed_us,
   output logic                                 rsp_pushed,
   output logic                                 rsp_update,
   output logic                                 rsp_max_reached,
   output logic                                 rsp_flow_valid,
   output logic [4:0]                           rsp_inlier_count,
   output logic [15:0]                          rsp_consec_outliers,
   output logic [7:0]                           rsp_outlier_total
);
   import ofsq_pkg::*;

   cfg_type    cfg;
   frame_type  frame_ff;
   logic       frame_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   ofsq_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Frame moves to the result register when that register is free or drains
   assign advance   = frame_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !frame_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
      end else if (req_ready) begin
         frame_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         frame_ff.delta_x         <= req_delta_x;
         frame_ff.delta_y         <= req_delta_y;
         frame_ff.surface_quality <= req_surface_quality;
         frame_ff.shutter_time    <= req_shutter_time;
         frame_ff.timestamp_us    <= req_timestamp_us;
      end
   end

   ofsq_qualifier #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_qualifier (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .frame   (frame_ff),
      .advance (advance),
      .result  (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_flow_x          = rsp_ff.flow_x;
   assign rsp_flow_y          = rsp_ff.flow_y;
   assign rsp_std_dev         = rsp_ff.std_dev;
   assign rsp_elapsed_us      = rsp_ff.elapsed_us;
   assign rsp_pushed          = rsp_ff.pushed;
   assign rsp_update          = rsp_ff.update;
   assign rsp_max_reached     = rsp_ff.max_reached;
   assign rsp_flow_valid      = rsp_ff.flow_valid;
   assign rsp_inlier_count    = rsp_ff.inlier_count;
   assign rsp_consec_outliers = rsp_ff.consec_outliers;
   assign rsp_outlier_total   = rsp_ff.outlier_total;

endmodule

`default_nettype wire
